// ===== design/cfcpp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfcpp_pkg
// Shared types, record codes and tag layout for the class file pool parser.
// ----------------------------------------------------------------------------
package cfcpp_pkg;

	localparam int INDEX_BITS = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [3:0] KIND_MAGIC = 4'd0;
	localparam logic [3:0] KIND_MINOR = 4'd1;
	localparam logic [3:0] KIND_MAJOR = 4'd2;
	localparam logic [3:0] KIND_COUNT = 4'd3;
	localparam logic [3:0] KIND_ENTRY = 4'd4;
	localparam logic [3:0] KIND_FLAGS = 4'd5;
	localparam logic [3:0] KIND_THIS = 4'd6;
	localparam logic [3:0] KIND_SUPER = 4'd7;
	localparam logic [3:0] KIND_BAD_TAG = 4'd8;
	localparam logic [3:0] KIND_UTF8 = 4'd9;

	localparam logic [7:0] TAG_UTF8 = 8'd1;
	localparam logic [7:0] TAG_INTEGER = 8'd3;
	localparam logic [7:0] TAG_FLOAT = 8'd4;
	localparam logic [7:0] TAG_LONG = 8'd5;
	localparam logic [7:0] TAG_DOUBLE = 8'd6;
	localparam logic [7:0] TAG_CLASS = 8'd7;
	localparam logic [7:0] TAG_STRING = 8'd8;
	localparam logic [7:0] TAG_FIELDREF = 8'd9;
	localparam logic [7:0] TAG_METHODREF = 8'd10;
	localparam logic [7:0] TAG_IMETHODREF = 8'd11;
	localparam logic [7:0] TAG_NAME_TYPE = 8'd12;
	localparam logic [7:0] TAG_METHOD_HANDLE = 8'd15;
	localparam logic [7:0] TAG_METHOD_TYPE = 8'd16;
	localparam logic [7:0] TAG_INVOKE_DYN = 8'd18;

	typedef enum logic [12:0] {
		PH_MAGIC   = 13'b0000000000001,
		PH_MINOR   = 13'b0000000000010,
		PH_MAJOR   = 13'b0000000000100,
		PH_COUNT   = 13'b0000000001000,
		PH_TAG     = 13'b0000000010000,
		PH_FIELDS  = 13'b0000000100000,
		PH_ULEN    = 13'b0000001000000,
		PH_UBYTES  = 13'b0000010000000,
		PH_FLAGS   = 13'b0000100000000,
		PH_THIS    = 13'b0001000000000,
		PH_SUPER   = 13'b0010000000000,
		PH_DONE    = 13'b0100000000000,
		PH_STOPPED = 13'b1000000000000
	} phase_t;

	typedef struct packed {
		logic [3:0]            kind;
		logic [INDEX_BITS-1:0] idx;
		logic [7:0]            tag;
		logic [31:0]           val_a;
		logic [31:0]           val_b;
		logic                  last;
	} rec_t;

	typedef struct packed {
		logic       known;
		logic [3:0] total;
		logic [2:0] second;
	} layout_t;

	function automatic layout_t tag_layout(input logic [7:0] tag);
		layout_t l;
		l = '0;
		case (tag)
			TAG_INTEGER, TAG_FLOAT: l = '{known: 1'b1, total: 4'd4, second: 3'd0};
			TAG_LONG, TAG_DOUBLE: l = '{known: 1'b1, total: 4'd8, second: 3'd4};
			TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE:
				l = '{known: 1'b1, total: 4'd2, second: 3'd0};
			TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF, TAG_NAME_TYPE, TAG_INVOKE_DYN:
				l = '{known: 1'b1, total: 4'd4, second: 3'd2};
			TAG_METHOD_HANDLE: l = '{known: 1'b1, total: 4'd3, second: 3'd2};
			default: l = '0;
		endcase
		return l;
	endfunction

endpackage

// ===== design/cfcpp_front.sv =====
// ----------------------------------------------------------------------------
// cfcpp_front
// Byte parser: gathers big-endian fields and emits one record per finished field.
// ----------------------------------------------------------------------------
module cfcpp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                q_full,
	input  logic [7:0]          data_byte,
	input  logic                restart,
	output logic                push,
	output cfcpp_pkg::rec_t     rec
);
	import cfcpp_pkg::*;

	localparam logic [INDEX_BITS-1:0] SlotOne = INDEX_BITS'(1);
	localparam logic [INDEX_BITS-1:0] IndexMax = {INDEX_BITS{1'b1}};

	phase_t                phase_q, phase_n, ph;
	logic [2:0]            cnt_q, cnt_n, cnt;
	logic [63:0]           acc_q, acc_n, acc;
	logic [INDEX_BITS-1:0] total_q, total_n, total;
	logic [INDEX_BITS-1:0] slot_q, slot_n, slot;
	logic [7:0]            tag_q, tag_n, tag;
	logic [15:0]           left_q, left_n, left;

	logic                  accept;
	logic [63:0]           acc_shift;
	logic [3:0]            cnt_inc;
	logic [3:0]            need;
	logic                  field_done;
	logic [1:0]            step;
	logic                  do_step;
	logic [INDEX_BITS:0]   slot_sum;
	layout_t               lay_cur, lay_in;
	logic                  emit;

	assign accept = in_valid && !q_full;
	assign push = accept && emit;

	always_comb begin
		ph = restart ? PH_MAGIC : phase_q;
		cnt = restart ? 3'd0 : cnt_q;
		acc = restart ? 64'd0 : acc_q;
		total = restart ? '0 : total_q;
		slot = restart ? SlotOne : slot_q;
		tag = restart ? 8'd0 : tag_q;
		left = restart ? 16'd0 : left_q;

		acc_shift = {acc[55:0], data_byte};
		cnt_inc = {1'b0, cnt} + 4'd1;
		lay_cur = tag_layout(tag);
		lay_in = tag_layout(data_byte);

		phase_n = ph;
		cnt_n = cnt;
		acc_n = acc;
		total_n = total;
		slot_n = slot;
		tag_n = tag;
		left_n = left;
		emit = 1'b0;
		rec = '0;
		step = 2'd0;
		do_step = 1'b0;
		need = 4'd2;
		field_done = 1'b0;

		case (ph)
			PH_MAGIC, PH_MINOR, PH_MAJOR, PH_COUNT, PH_FLAGS, PH_THIS, PH_SUPER: begin
				need = (ph == PH_MAGIC) ? 4'd4 : 4'd2;
				field_done = cnt_inc >= need;
				if (field_done) begin
					cnt_n = 3'd0;
					acc_n = 64'd0;
					emit = 1'b1;
					rec.val_a = acc_shift[31:0];
					case (ph)
						PH_MAGIC: begin
							rec.kind = KIND_MAGIC;
							phase_n = PH_MINOR;
						end
						PH_MINOR: begin
							rec.kind = KIND_MINOR;
							phase_n = PH_MAJOR;
						end
						PH_MAJOR: begin
							rec.kind = KIND_MAJOR;
							phase_n = PH_COUNT;
						end
						PH_COUNT: begin
							rec.kind = KIND_COUNT;
							if (32'(acc_shift[15:0]) > 32'(IndexMax))
								total_n = IndexMax;
							else
								total_n = INDEX_BITS'(acc_shift[15:0]);
							slot_n = SlotOne;
							phase_n = (total_n <= SlotOne) ? PH_FLAGS : PH_TAG;
						end
						PH_FLAGS: begin
							rec.kind = KIND_FLAGS;
							phase_n = PH_THIS;
						end
						PH_THIS: begin
							rec.kind = KIND_THIS;
							phase_n = PH_SUPER;
						end
						default: begin
							rec.kind = KIND_SUPER;
							phase_n = PH_DONE;
						end
					endcase
				end else begin
					cnt_n = cnt_inc[2:0];
					acc_n = acc_shift;
				end
			end
			PH_TAG: begin
				tag_n = data_byte;
				cnt_n = 3'd0;
				acc_n = 64'd0;
				if (data_byte == TAG_UTF8) begin
					phase_n = PH_ULEN;
				end else if (lay_in.known) begin
					phase_n = PH_FIELDS;
				end else begin
					phase_n = PH_STOPPED;
					emit = 1'b1;
					rec.kind = KIND_BAD_TAG;
					rec.idx = slot;
					rec.tag = data_byte;
				end
			end
			PH_FIELDS: begin
				if (!lay_cur.known) begin
					phase_n = PH_STOPPED;
				end else if (cnt_inc >= lay_cur.total) begin
					cnt_n = 3'd0;
					acc_n = 64'd0;
					emit = 1'b1;
					rec.kind = KIND_ENTRY;
					rec.idx = slot;
					rec.tag = tag;
					case (lay_cur.second)
						3'd4: begin
							rec.val_a = acc_shift[63:32];
							rec.val_b = acc_shift[31:0];
						end
						3'd2: begin
							rec.val_a = {16'd0, acc_shift[31:16]};
							rec.val_b = {16'd0, acc_shift[15:0]};
						end
						default: rec.val_a = acc_shift[31:0];
					endcase
					do_step = 1'b1;
					step = (tag == TAG_LONG || tag == TAG_DOUBLE) ? 2'd2 : 2'd1;
				end else begin
					cnt_n = cnt_inc[2:0];
					acc_n = acc_shift;
				end
			end
			PH_ULEN: begin
				if (cnt_inc >= 4'd2) begin
					cnt_n = 3'd0;
					acc_n = 64'd0;
					left_n = acc_shift[15:0];
					emit = 1'b1;
					rec.kind = KIND_ENTRY;
					rec.idx = slot;
					rec.tag = tag;
					rec.val_a = {16'd0, acc_shift[15:0]};
					if (acc_shift[15:0] == 16'd0) begin
						do_step = 1'b1;
						step = 2'd1;
					end else begin
						phase_n = PH_UBYTES;
					end
				end else begin
					cnt_n = cnt_inc[2:0];
					acc_n = acc_shift;
				end
			end
			PH_UBYTES: begin
				emit = 1'b1;
				rec.kind = KIND_UTF8;
				rec.idx = slot;
				rec.tag = tag;
				rec.val_a = {24'd0, data_byte};
				rec.last = left <= 16'd1;
				if (rec.last) begin
					do_step = 1'b1;
					step = 2'd1;
				end else begin
					left_n = left - 16'd1;
				end
			end
			default: begin
				phase_n = ph;
			end
		endcase

		slot_sum = {1'b0, slot} + (INDEX_BITS+1)'(step);
		if (do_step) begin
			slot_n = slot_sum[INDEX_BITS-1:0];
			phase_n = (slot_sum >= {1'b0, total}) ? PH_FLAGS : PH_TAG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			cnt_q <= 3'd0;
			acc_q <= 64'd0;
			total_q <= '0;
			slot_q <= SlotOne;
			tag_q <= 8'd0;
			left_q <= 16'd0;
		end else if (accept) begin
			phase_q <= phase_n;
			cnt_q <= cnt_n;
			acc_q <= acc_n;
			total_q <= total_n;
			slot_q <= slot_n;
			tag_q <= tag_n;
			left_q <= left_n;
		end
	end

	a_quiet_when_finished: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !restart && (phase_q == PH_DONE || phase_q == PH_STOPPED)) |-> !push)
		else $error("record pushed after parse finished");

	a_stopped_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !restart && phase_q == PH_STOPPED) |=> phase_q == PH_STOPPED)
		else $error("stopped parse resumed without restart");

	a_restart_magic: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && restart) |=> (phase_q == PH_MAGIC || phase_q == PH_MINOR))
		else $error("restart did not return to header parse");

endmodule

// ===== design/cfcpp_queue.sv =====
// ----------------------------------------------------------------------------
// cfcpp_queue
// Two-entry record queue between the byte parser and the output stage.
// ----------------------------------------------------------------------------
module cfcpp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cfcpp_pkg::rec_t push_rec,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output cfcpp_pkg::rec_t head
);
	import cfcpp_pkg::*;

	localparam int PtrBits = $clog2(QUEUE_DEPTH);
	localparam int CntBits = $clog2(QUEUE_DEPTH + 1);

	rec_t               mem_q [QUEUE_DEPTH];
	logic [PtrBits-1:0] wr_q;
	logic [PtrBits-1:0] rd_q;
	logic [CntBits-1:0] cnt_q;

	assign full = cnt_q == CntBits'(QUEUE_DEPTH);
	assign not_empty = cnt_q != '0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PtrBits'(1);
			if (pop)
				rd_q <= (rd_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PtrBits'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CntBits'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CntBits'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntBits'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

// ===== design/cfcpp_back.sv =====
// ----------------------------------------------------------------------------
// cfcpp_back
// Output stage: moves queued records into the result register.
// ----------------------------------------------------------------------------
module cfcpp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_not_empty,
	input  cfcpp_pkg::rec_t q_head,
	output logic            pop,
	input  logic            out_stall,
	output logic            out_valid,
	output cfcpp_pkg::rec_t out_rec
);
	import cfcpp_pkg::*;

	logic valid_q;
	rec_t rec_q;

	assign pop = q_not_empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_rec = rec_q;

	always_ff @(posedge clk) begin
		if (pop)
			rec_q <= q_head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (!out_stall)
			valid_q <= 1'b0;
	end

	a_fill_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> valid_q)
		else $error("popped record not presented");

	a_drain_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(q_not_empty && !valid_q) |-> pop)
		else $error("idle output stage left queue waiting");

	a_hold_until_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_stall) |=> valid_q)
		else $error("stalled result dropped");

endmodule

// ===== design/class_file_constant_pool_parser_top.sv =====
// ----------------------------------------------------------------------------
// class_file_constant_pool_parser_top
// Byte-serial class file header and constant pool parser.
//
//   channel  dir  handshake            word
//   input    in   in_valid/in_stall    data_byte, restart
//   output   out  out_valid/out_stall  rec_kind, pool_index, entry_tag,
//                                      value_a, value_b, run_last
//
// One byte is taken per cycle unless the queue is full; each record is written
// into the queue, then into the result register. The byte parser updates its field state for each byte.
// A two-entry queue and the result register absorb output stalls; input
// stalls only when the queue is full.
// Reset clears parse state, queue and result valid; no clearing pass.
// ----------------------------------------------------------------------------
module class_file_constant_pool_parser_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        data_byte,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [3:0]                        rec_kind,
	output logic [cfcpp_pkg::INDEX_BITS-1:0]  pool_index,
	output logic [7:0]                        entry_tag,
	output logic [31:0]                       value_a,
	output logic [31:0]                       value_b,
	output logic                              run_last
);
	import cfcpp_pkg::*;

	logic push;
	logic pop;
	logic q_full;
	logic q_not_empty;
	rec_t front_rec;
	rec_t q_head;
	rec_t out_rec;

	assign in_stall = q_full;

	cfcpp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.q_full    (q_full),
		.data_byte (data_byte),
		.restart   (restart),
		.push      (push),
		.rec       (front_rec)
	);

	cfcpp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (front_rec),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	cfcpp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_rec     (out_rec)
	);

	assign rec_kind = out_rec.kind;
	assign pool_index = out_rec.idx;
	assign entry_tag = out_rec.tag;
	assign value_a = out_rec.val_a;
	assign value_b = out_rec.val_b;
	assign run_last = out_rec.last;

endmodule

// ===== test/cfcpp_record_checker.sv =====
// ----------------------------------------------------------------------------
// cfcpp_record_checker
// Watches both channels of the class file pool parser, predicts the record
// stream from every accepted word and compares each delivered record, field
// by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module cfcpp_record_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [7:0]                        data_byte,
	input  logic                              restart,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [3:0]                        rec_kind,
	input  logic [cfcpp_pkg::INDEX_BITS-1:0]  pool_index,
	input  logic [7:0]                        entry_tag,
	input  logic [31:0]                       value_a,
	input  logic [31:0]                       value_b,
	input  logic                              run_last,
	output int                                mismatches,
	output int                                waiting,
	output int                                checked
);

	import cfcpp_pkg::*;

	localparam logic [31:0] SLOT_MAX = (32'd1 << INDEX_BITS) - 32'd1;

	phase_t      parse_ph;
	logic [2:0]  nbytes;
	logic [63:0] acc;
	logic [31:0] pool_total;
	logic [31:0] slot;
	logic [7:0]  cur_tag;
	logic [15:0] text_left;
	rec_t        pending_records[$];
	rec_t        got_rec;
	rec_t        want_rec;

	initial begin
		mismatches = 0;
		waiting = 0;
		checked = 0;
	end

	function automatic void reset_parse();
		parse_ph = PH_MAGIC;
		nbytes = '0;
		acc = '0;
		pool_total = '0;
		slot = 32'd1;
		cur_tag = '0;
		text_left = '0;
	endfunction

	// shift a byte into the field; true once need bytes are in
	function automatic bit shift_in(input logic [7:0] b, input int need);
		acc = {acc[55:0], b};
		if (nbytes + 1 >= need) begin
			nbytes = '0;
			return 1'b1;
		end
		nbytes = nbytes + 3'd1;
		return 1'b0;
	endfunction

	function automatic bit tag_shape(input logic [7:0] t, output int total,
			output int second);
		total = 0;
		second = 0;
		case (t)
			TAG_INTEGER, TAG_FLOAT: total = 4;
			TAG_LONG, TAG_DOUBLE: begin
				total = 8;
				second = 4;
			end
			TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: total = 2;
			TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF, TAG_NAME_TYPE,
			TAG_INVOKE_DYN: begin
				total = 4;
				second = 2;
			end
			TAG_METHOD_HANDLE: begin
				total = 3;
				second = 2;
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic void advance_slot(input logic [31:0] step);
		slot = slot + step;
		parse_ph = (slot >= pool_total) ? PH_FLAGS : PH_TAG;
	endfunction

	function automatic void note(input logic [3:0] kind, input logic [31:0] idx,
			input logic [7:0] t, input logic [31:0] a, input logic [31:0] b,
			input logic last);
		rec_t r;
		r.kind = kind;
		r.idx = idx[INDEX_BITS-1:0];
		r.tag = t;
		r.val_a = a;
		r.val_b = b;
		r.last = last;
		pending_records.push_back(r);
	endfunction

	function automatic void parse_byte(input logic [7:0] b, input logic rs);
		int          need;
		int          total;
		int          second;
		logic [63:0] v;
		logic [63:0] low_mask;
		logic [3:0]  kind;
		logic [31:0] idx;
		logic        last;
		if (rs)
			reset_parse();
		case (parse_ph)
			PH_MAGIC, PH_MINOR, PH_MAJOR, PH_COUNT, PH_FLAGS, PH_THIS, PH_SUPER: begin
				need = (parse_ph == PH_MAGIC) ? 4 : 2;
				if (shift_in(b, need)) begin
					v = {32'd0, acc[31:0]};
					acc = '0;
					case (parse_ph)
						PH_MAGIC: begin
							kind = KIND_MAGIC;
							parse_ph = PH_MINOR;
						end
						PH_MINOR: begin
							kind = KIND_MINOR;
							parse_ph = PH_MAJOR;
						end
						PH_MAJOR: begin
							kind = KIND_MAJOR;
							parse_ph = PH_COUNT;
						end
						PH_COUNT: begin
							kind = KIND_COUNT;
							pool_total = (v > {32'd0, SLOT_MAX}) ? SLOT_MAX : v[31:0];
							slot = 32'd1;
							parse_ph = (slot >= pool_total) ? PH_FLAGS : PH_TAG;
						end
						PH_FLAGS: begin
							kind = KIND_FLAGS;
							parse_ph = PH_THIS;
						end
						PH_THIS: begin
							kind = KIND_THIS;
							parse_ph = PH_SUPER;
						end
						default: begin
							kind = KIND_SUPER;
							parse_ph = PH_DONE;
						end
					endcase
					note(kind, 32'd0, 8'd0, v[31:0], 32'd0, 1'b0);
				end
			end
			PH_TAG: begin
				cur_tag = b;
				nbytes = '0;
				acc = '0;
				if (b == TAG_UTF8)
					parse_ph = PH_ULEN;
				else if (tag_shape(b, total, second))
					parse_ph = PH_FIELDS;
				else begin
					parse_ph = PH_STOPPED;
					note(KIND_BAD_TAG, slot, b, 32'd0, 32'd0, 1'b0);
				end
			end
			PH_FIELDS: begin
				if (!tag_shape(cur_tag, total, second))
					parse_ph = PH_STOPPED;
				else if (shift_in(b, total)) begin
					v = acc;
					acc = '0;
					idx = slot;
					low_mask = (64'd1 << (8 * second)) - 64'd1;
					advance_slot((cur_tag == TAG_LONG || cur_tag == TAG_DOUBLE) ? 32'd2 : 32'd1);
					note(KIND_ENTRY, idx, cur_tag, 32'(v >> (8 * second)),
						(second != 0) ? 32'(v & low_mask) : 32'd0, 1'b0);
				end
			end
			PH_ULEN: begin
				if (shift_in(b, 2)) begin
					text_left = acc[15:0];
					acc = '0;
					note(KIND_ENTRY, slot, cur_tag, {16'd0, text_left}, 32'd0, 1'b0);
					if (text_left == 16'd0)
						advance_slot(32'd1);
					else
						parse_ph = PH_UBYTES;
				end
			end
			PH_UBYTES: begin
				last = (text_left <= 16'd1);
				note(KIND_UTF8, slot, cur_tag, {24'd0, b}, 32'd0, last);
				if (last)
					advance_slot(32'd1);
				else
					text_left = text_left - 16'd1;
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatches = mismatches + 1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_parse();
			pending_records.delete();
		end else begin
			if (out_valid && !out_stall) begin
				got_rec = '{kind: rec_kind, idx: pool_index, tag: entry_tag,
					val_a: value_a, val_b: value_b, last: run_last};
				if (pending_records.size() == 0) begin
					$display("%0t: unexpected record, expected none, got kind %0h value_a %0h",
						$time, rec_kind, value_a);
					mismatches = mismatches + 1;
				end else begin
					want_rec = pending_records.pop_front();
					check_field("rec_kind", 32'(want_rec.kind), 32'(got_rec.kind));
					check_field("pool_index", 32'(want_rec.idx), 32'(got_rec.idx));
					check_field("entry_tag", 32'(want_rec.tag), 32'(got_rec.tag));
					check_field("value_a", want_rec.val_a, got_rec.val_a);
					check_field("value_b", want_rec.val_b, got_rec.val_b);
					check_field("run_last", 32'(want_rec.last), 32'(got_rec.last));
					checked = checked + 1;
				end
			end
			if (in_valid && !in_stall)
				parse_byte(data_byte, restart);
		end
		waiting <= pending_records.size();
	end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Feeds the class file pool parser with directed and random class files,
// well formed, truncated and with bad tags, under several idle and stall
// patterns, and reports the verdict from the record checker.
// ----------------------------------------------------------------------------
module testbench;

	import cfcpp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int BYTES_PER_STAGE = 450;
	localparam logic [8*13-1:0] KNOWN_TAGS = {TAG_INTEGER, TAG_FLOAT, TAG_LONG,
		TAG_DOUBLE, TAG_CLASS, TAG_STRING, TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF,
		TAG_NAME_TYPE, TAG_METHOD_HANDLE, TAG_METHOD_TYPE, TAG_INVOKE_DYN};

	typedef struct packed {
		logic [7:0] d;
		logic       r;
	} word_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [7:0]             data_byte = '0;
	logic                   restart = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [3:0]             rec_kind;
	logic [INDEX_BITS-1:0]  pool_index;
	logic [7:0]             entry_tag;
	logic [31:0]            value_a;
	logic [31:0]            value_b;
	logic                   run_last;

	int    mismatches;
	int    waiting;
	int    checked;
	int    send_pct = 0;
	int    recv_pct = 0;
	int    cycle_count = 0;
	int    bytes_sent = 0;
	int    files_sent = 0;
	bit    hold_go = 1'b0;
	logic  hold_on = 1'b0;
	word_t file_q[$];

	class_file_constant_pool_parser_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.rec_kind   (rec_kind),
		.pool_index (pool_index),
		.entry_tag  (entry_tag),
		.value_a    (value_a),
		.value_b    (value_b),
		.run_last   (run_last)
	);

	cfcpp_record_checker i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.rec_kind   (rec_kind),
		.pool_index (pool_index),
		.entry_tag  (entry_tag),
		.value_a    (value_a),
		.value_b    (value_b),
		.run_last   (run_last),
		.mismatches (mismatches),
		.waiting    (waiting),
		.checked    (checked)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d records outstanding", cycle_count, waiting);
		$display("TB_ERROR");
		$finish;
	end

	// output side: random stalls, overridden by the long hold
	initial begin
		forever begin
			@(posedge clk);
			out_stall <= hold_on || ($urandom_range(99) < recv_pct);
		end
	end

	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (300) @(posedge clk);
		hold_on <= 1'b0;
	end

	task automatic push(input logic [7:0] d);
		file_q.push_back('{d: d, r: 1'b0});
	endtask

	task automatic push_u2(input logic [15:0] v);
		push(v[15:8]);
		push(v[7:0]);
	endtask

	task automatic push_u4(input logic [31:0] v);
		push_u2(v[31:16]);
		push_u2(v[15:0]);
	endtask

	task automatic send_word(input word_t w);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= w.d;
		restart <= w.r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_file();
		foreach (file_q[i])
			send_word(file_q[i]);
		bytes_sent += file_q.size();
		files_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
	endtask

	task automatic build_file();
		int          sel;
		int          slot;
		int          n;
		int          len;
		int          keep;
		logic [31:0] count;
		logic [7:0]  t;
		layout_t     lay;
		bit          stopped;
		file_q.delete();
		stopped = 1'b0;
		push_u4($urandom);
		push_u2(16'($urandom_range(16'hFFFF)));
		push_u2(16'($urandom_range(16'hFFFF)));
		sel = $urandom_range(99);
		if (sel < 8)
			count = $urandom_range(1);
		else if (sel < 14)
			count = $urandom_range(16'hFFFF, 16'h8000);
		else
			count = $urandom_range(12, 2);
		push_u2(count[15:0]);
		slot = 1;
		n = 0;
		while (slot < count && !stopped) begin
			sel = $urandom_range(99);
			if (sel < 3 || n >= 14) begin
				do begin
					t = 8'($urandom_range(255));
					lay = tag_layout(t);
				end while (t == TAG_UTF8 || lay.known);
				push(t);
				repeat ($urandom_range(3)) push(8'($urandom));
				stopped = 1'b1;
			end else if (sel < 35) begin
				push(TAG_UTF8);
				if ($urandom_range(49) == 0) begin
					// huge length, cut short by the next file
					push_u2(16'($urandom_range(16'hFFFF, 16'h0100)));
					repeat ($urandom_range(10, 1)) push(8'($urandom));
					stopped = 1'b1;
				end else begin
					len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
					push_u2(len[15:0]);
					repeat (len) push(8'($urandom));
				end
				slot++;
				n++;
			end else begin
				t = KNOWN_TAGS[8 * $urandom_range(12) +: 8];
				lay = tag_layout(t);
				push(t);
				repeat (lay.total) push(8'($urandom));
				slot += (t == TAG_LONG || t == TAG_DOUBLE) ? 2 : 1;
				n++;
			end
		end
		if (!stopped) begin
			push_u2(16'($urandom_range(16'hFFFF)));
			push_u2(16'($urandom_range(16'hFFFF)));
			push_u2(16'($urandom_range(16'hFFFF)));
			repeat ($urandom_range(3)) push(8'($urandom));
			if ($urandom_range(9) == 0) begin
				keep = $urandom_range(file_q.size(), 1);
				while (file_q.size() > keep)
					void'(file_q.pop_back());
			end
		end
		file_q[0].r = ($urandom_range(19) != 0);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// long entry in the last slot, header extremes, ignored tail
		file_q.delete();
		push_u4(32'hFFFF_FFFF);
		push_u2(16'h0000);
		push_u2(16'hFFFF);
		push_u2(16'd2);
		push(TAG_LONG);
		push_u4(32'hFFFF_FFFF);
		push_u4(32'h0000_0000);
		push_u2(16'hFFFF);
		push_u2(16'h0000);
		push_u2(16'h1234);
		push(8'hA5);
		file_q[0].r = 1'b1;
		send_file();

		// largest pool count, empty utf8, unknown tag, ignored tail
		file_q.delete();
		push_u4(32'h0000_0000);
		push_u2(16'h0001);
		push_u2(16'h8000);
		push_u2(16'hFFFF);
		push(TAG_UTF8);
		push_u2(16'h0000);
		push(8'hFF);
		push(8'h07);
		file_q[0].r = 1'b1;
		send_file();
		wait_drained();

		for (int stage = 0; stage < 4; stage++) begin
			case (stage)
				0: begin
					send_pct = 0;
					recv_pct = 0;
					hold_go = 1'b1;
				end
				1: begin
					send_pct = 72;
					recv_pct = 0;
				end
				2: begin
					send_pct = 0;
					recv_pct = 72;
				end
				default: begin
					send_pct = 22;
					recv_pct = 22;
				end
			endcase
			for (int sent = 0; sent < BYTES_PER_STAGE; sent += file_q.size()) begin
				build_file();
				send_file();
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		$display("sent %0d bytes in %0d class files, %0d records checked", bytes_sent,
			files_sent, checked);
		$display("stages: free running, sender gaps, receiver stalls, both, one long hold");
		if (waiting != 0)
			$display("%0t: %0d expected records never arrived", $time, waiting);
		if (mismatches == 0 && waiting == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
